### rtl/least_squares_line_fit_unit_macros.svh
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit_macros
// assertion macros shared by the checker of the line fit unit
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_FIT_UNIT_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_UNIT_MACROS_SVH

// same-cycle implication, idle during reset
`define LSLF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, idle during reset
`define LSLF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds through reset
`define LSLF_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lslf_pkg.sv
// ----------------------------------------------------------------------------
// lslf_pkg
// types and constants of the least-squares line fit unit
// ----------------------------------------------------------------------------
package lslf_pkg;

   localparam int COORD_BITS = 16;
   localparam int MAX_POINTS = 65536;
   localparam int FRAC_BITS  = 16;

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SX_W   = COORD_BITS + CNT_W;
   localparam int SXX_W  = 2 * COORD_BITS + CNT_W - 2;
   localparam int SXY_W  = 2 * COORD_BITS + CNT_W - 1;
   localparam int OUT_W  = 48;
   localparam int RSQ_W  = 17;
   localparam int STAT_W = 2;

   localparam int ALU_W     = 144;
   localparam int ALU_SW    = ALU_W + 1;
   localparam int ALU_CNT_W = $clog2(ALU_W);

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_VERT = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FLAT = 2'd2;
   localparam logic [STAT_W-1:0] STAT_SAT  = 2'd3;

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   typedef struct packed {
      logic start;
      logic op;
   } alu_req_type;

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SX_W-1:0]  sx;
      logic signed [SX_W-1:0]  sy;
      logic [SXX_W-1:0]        sxx;
      logic [SXX_W-1:0]        syy;
      logic signed [SXY_W-1:0] sxy;
   } sums_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] slope;
      logic signed [OUT_W-1:0] intercept;
      logic [RSQ_W-1:0]        r_squared;
      logic [STAT_W-1:0]       fit_status;
   } fit_result_type;

   typedef struct packed {
      logic             sat;
      logic [OUT_W-1:0] val;
   } sat_type;

   function automatic logic [ALU_W-1:0] mag_of(input logic signed [ALU_SW-1:0] v);
      logic signed [ALU_SW-1:0] n;
      n = -v;
      return v[ALU_SW-1] ? n[ALU_W-1:0] : v[ALU_W-1:0];
   endfunction

   function automatic sat_type sat48(input logic neg, input logic [ALU_W-1:0] m);
      sat_type r;
      logic [ALU_W-1:0] n;
      n = -m;
      r.sat = 1'b0;
      if (neg) begin
         if (m > (ALU_W'(1) << (OUT_W - 1))) begin
            r.sat = 1'b1;
            r.val = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            r.val = n[OUT_W-1:0];
         end
      end else begin
         if (m > ((ALU_W'(1) << (OUT_W - 1)) - ALU_W'(1))) begin
            r.sat = 1'b1;
            r.val = {1'b0, {(OUT_W-1){1'b1}}};
         end else begin
            r.val = m[OUT_W-1:0];
         end
      end
      return r;
   endfunction

endpackage

### rtl/lslf_accum.sv
// ----------------------------------------------------------------------------
// lslf_accum
// running count and power sums of the incoming points
// ----------------------------------------------------------------------------
module lslf_accum (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic signed [lslf_pkg::COORD_BITS-1:0] x_value,
   input  logic signed [lslf_pkg::COORD_BITS-1:0] y_value,
   input  logic                                  clear,
   output lslf_pkg::sums_type                    sums
);
   import lslf_pkg::*;

   localparam int PW = 2 * COORD_BITS;

   sums_type sums_ff, sums_in;
   logic signed [PW-1:0] xx_prod, yy_prod, xy_prod;

   always_comb begin
      xx_prod = x_value * x_value;
      yy_prod = y_value * y_value;
      xy_prod = x_value * y_value;
      sums_in = sums_ff;
      if (clear) begin
         sums_in = '0;
      end else if (accept && (sums_ff.count < CNT_W'(MAX_POINTS))) begin
         sums_in.count = sums_ff.count + CNT_W'(1);
         sums_in.sx    = sums_ff.sx + SX_W'(x_value);
         sums_in.sy    = sums_ff.sy + SX_W'(y_value);
         sums_in.sxx   = sums_ff.sxx + {{(SXX_W-PW){1'b0}}, xx_prod};
         sums_in.syy   = sums_ff.syy + {{(SXX_W-PW){1'b0}}, yy_prod};
         sums_in.sxy   = sums_ff.sxy + {{(SXY_W-PW){xy_prod[PW-1]}}, xy_prod};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else begin
         sums_ff <= sums_in;
      end
   end

   assign sums = sums_ff;

endmodule

### rtl/lslf_alu.sv
// ----------------------------------------------------------------------------
// lslf_alu
// shared bit-serial unsigned multiplier and restoring divider
// ----------------------------------------------------------------------------
module lslf_alu (
   input  logic                         clock,
   input  logic                         reset,
   input  lslf_pkg::alu_req_type        req,
   input  logic [lslf_pkg::ALU_W-1:0]   op_a,
   input  logic [lslf_pkg::ALU_W-1:0]   op_b,
   output logic                         done,
   output logic [lslf_pkg::ALU_W-1:0]   result
);
   import lslf_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 op_ff, op_in;
   logic [ALU_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ALU_W-1:0]     a_ff, a_in;
   logic [ALU_W-1:0]     b_ff, b_in;
   logic [ALU_W-1:0]     acc_ff, acc_in;
   logic [ALU_W-1:0]     rem_ff, rem_in;
   logic [ALU_W:0]       rem_w;
   logic                 ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      rem_w   = {rem_ff, a_ff[ALU_W-1]};
      ge      = rem_w >= {1'b0, b_ff};
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               acc_in = {acc_ff[ALU_W-2:0], 1'b0} + (b_ff[ALU_W-1] ? a_ff : '0);
               b_in   = {b_ff[ALU_W-2:0], 1'b0};
            end
            OP_DIV: begin
               rem_in = ge ? ALU_W'(rem_w - {1'b0, b_ff}) : rem_w[ALU_W-1:0];
               acc_in = {acc_ff[ALU_W-2:0], ge};
               a_in   = {a_ff[ALU_W-2:0], 1'b0};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff + ALU_CNT_W'(1);
         if (cnt_ff == ALU_CNT_W'(ALU_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

### rtl/lslf_seq.sv
// ----------------------------------------------------------------------------
// lslf_seq
// sequencer that forms the spreads and quotients of the fit on the shared unit
// ----------------------------------------------------------------------------
module lslf_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  lslf_pkg::sums_type            sums,
   input  logic                          out_free,
   input  logic                          alu_done,
   input  logic [lslf_pkg::ALU_W-1:0]    alu_result,
   output lslf_pkg::alu_req_type         alu_req,
   output logic [lslf_pkg::ALU_W-1:0]    alu_a,
   output logic [lslf_pkg::ALU_W-1:0]    alu_b,
   output logic                          busy,
   output logic                          out_load,
   output lslf_pkg::fit_result_type      result
);
   import lslf_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_PROD    = 3'd1;
   localparam logic [2:0] ST_SLOPE   = 3'd2;
   localparam logic [2:0] ST_ICPT    = 3'd3;
   localparam logic [2:0] ST_RSQ_NUM = 3'd4;
   localparam logic [2:0] ST_RSQ_DEN = 3'd5;
   localparam logic [2:0] ST_RSQ_DIV = 3'd6;
   localparam logic [2:0] ST_OUT     = 3'd7;

   localparam logic [ALU_W-1:0] RSQ_ONE  = ALU_W'(1) << FRAC_BITS;
   localparam logic [ALU_W-1:0] RSQ_CLIP = ALU_W'((1 << RSQ_W) - 1);

   logic [2:0]               state_ff, state_in;
   logic [2:0]               k_ff, k_in;
   logic                     wait_ff, wait_in;
   logic                     sat_ff, sat_in;
   logic signed [ALU_SW-1:0] first_ff, first_in;
   logic signed [ALU_SW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ALU_SW-1:0] dxy_ff, dxy_in, inum_ff, inum_in;
   logic [ALU_W-1:0]         num_ff, num_in, den_ff, den_in;
   fit_result_type           res_ff, res_in;

   logic signed [ALU_SW-1:0] sa, sb, prod_s, diff;
   logic                     neg;
   logic                     op;
   logic [ALU_W-1:0]         q_rsq;
   sat_type                  sq;

   always_comb begin
      sa = '0;
      sb = '0;
      unique case (k_ff)
         3'd0: begin sa = ALU_SW'(sums.count); sb = ALU_SW'(sums.sxx); end
         3'd1: begin sa = ALU_SW'(sums.sx);    sb = ALU_SW'(sums.sx);  end
         3'd2: begin sa = ALU_SW'(sums.count); sb = ALU_SW'(sums.syy); end
         3'd3: begin sa = ALU_SW'(sums.sy);    sb = ALU_SW'(sums.sy);  end
         3'd4: begin sa = ALU_SW'(sums.count); sb = ALU_SW'(sums.sxy); end
         3'd5: begin sa = ALU_SW'(sums.sx);    sb = ALU_SW'(sums.sy);  end
         3'd6: begin sa = ALU_SW'(sums.sy);    sb = ALU_SW'(sums.sxx); end
         3'd7: begin sa = ALU_SW'(sums.sx);    sb = ALU_SW'(sums.sxy); end
         default: begin sa = '0; sb = '0; end
      endcase
      neg   = 1'b0;
      op    = OP_MUL;
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         ST_PROD: begin
            alu_a = mag_of(sa);
            alu_b = mag_of(sb);
            neg   = sa[ALU_SW-1] ^ sb[ALU_SW-1];
         end
         ST_SLOPE: begin
            op    = OP_DIV;
            alu_a = mag_of(dxy_ff) << FRAC_BITS;
            alu_b = mag_of(dx_ff);
            neg   = dxy_ff[ALU_SW-1] ^ dx_ff[ALU_SW-1];
         end
         ST_ICPT: begin
            op    = OP_DIV;
            alu_a = mag_of(inum_ff) << FRAC_BITS;
            alu_b = mag_of(dx_ff);
            neg   = inum_ff[ALU_SW-1] ^ dx_ff[ALU_SW-1];
         end
         ST_RSQ_NUM: begin
            alu_a = mag_of(dxy_ff);
            alu_b = mag_of(dxy_ff);
         end
         ST_RSQ_DEN: begin
            alu_a = mag_of(dx_ff);
            alu_b = mag_of(dy_ff);
         end
         ST_RSQ_DIV: begin
            op    = OP_DIV;
            alu_a = num_ff << FRAC_BITS;
            alu_b = den_ff;
         end
         default: begin
            op = OP_MUL;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      wait_in  = wait_ff;
      sat_in   = sat_ff;
      first_in = first_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dxy_in   = dxy_ff;
      inum_in  = inum_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      res_in   = res_ff;
      out_load = 1'b0;
      alu_req.start = 1'b0;
      alu_req.op    = op;
      prod_s = neg ? -ALU_SW'(alu_result) : ALU_SW'(alu_result);
      diff   = first_ff - prod_s;
      sq     = sat48(neg, alu_result);
      q_rsq  = (alu_result > RSQ_ONE) ? RSQ_ONE : alu_result;
      if (q_rsq > RSQ_CLIP) begin
         q_rsq = RSQ_CLIP;
      end
      if (state_ff != ST_IDLE && state_ff != ST_OUT && !wait_ff) begin
         alu_req.start = 1'b1;
         wait_in = 1'b1;
      end
      if (alu_done) begin
         wait_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PROD;
               k_in     = '0;
               sat_in   = 1'b0;
               wait_in  = 1'b0;
            end
         end
         ST_PROD: begin
            if (alu_done) begin
               k_in = k_ff + 3'd1;
               if (!k_ff[0]) begin
                  first_in = prod_s;
               end else begin
                  unique case (k_ff[2:1])
                     2'd0: dx_in   = diff;
                     2'd1: dy_in   = diff;
                     2'd2: dxy_in  = diff;
                     2'd3: inum_in = diff;
                     default: dx_in = diff;
                  endcase
               end
               if (k_ff == 3'd7) begin
                  if (dx_ff == '0) begin
                     res_in   = '0;
                     res_in.fit_status = STAT_VERT;
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_SLOPE;
                  end
               end
            end
         end
         ST_SLOPE: begin
            if (alu_done) begin
               res_in.slope = sq.val;
               sat_in       = sat_ff | sq.sat;
               state_in     = ST_ICPT;
            end
         end
         ST_ICPT: begin
            if (alu_done) begin
               res_in.intercept = sq.val;
               if (dy_ff == '0) begin
                  res_in.r_squared  = '0;
                  res_in.fit_status = (sat_ff | sq.sat) ? STAT_SAT : STAT_FLAT;
                  state_in = ST_OUT;
               end else begin
                  sat_in   = sat_ff | sq.sat;
                  state_in = ST_RSQ_NUM;
               end
            end
         end
         ST_RSQ_NUM: begin
            if (alu_done) begin
               num_in   = alu_result;
               state_in = ST_RSQ_DEN;
            end
         end
         ST_RSQ_DEN: begin
            if (alu_done) begin
               den_in   = alu_result;
               state_in = ST_RSQ_DIV;
            end
         end
         ST_RSQ_DIV: begin
            if (alu_done) begin
               res_in.r_squared  = q_rsq[RSQ_W-1:0];
               res_in.fit_status = sat_ff ? STAT_SAT : STAT_OK;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= 1'b0;
         k_ff     <= '0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         k_ff     <= k_in;
         sat_ff   <= sat_in;
      end
      first_ff <= first_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dxy_ff   <= dxy_in;
      inum_ff  <= inum_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      res_ff   <= res_in;
   end

   assign busy   = state_ff != ST_IDLE;
   assign result = res_ff;

endmodule

### rtl/least_squares_line_fit_unit.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit
// least-squares straight-line fit over a stream of signed integer points
// ----------------------------------------------------------------------------
// requests carry one point (x, y) and a last flag; a request is taken on a
// clock edge with req_valid high and req_stall low, one point per cycle
// while no fit is running
// a request with the last flag closes the set: from the next cycle req_stall
// is high for about 13 passes of the shared multiply/divide unit (eight
// products, two 48-bit quotients, two products and one quotient for
// r-squared); a vertical set ends after the eight products, a flat set
// after the two quotients
// the result (slope, intercept, r-squared, status) then sits in an output
// register until taken with rsp_valid high and rsp_stall low; while it waits
// new points are already accumulated, and a later fit holds its result
// until the register is free
// reset clears the sums, the sequencer and the output valid flag; the sums
// clear again as each result is loaded
// ----------------------------------------------------------------------------
module least_squares_line_fit_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [lslf_pkg::COORD_BITS-1:0] req_x_value,
   input  logic signed [lslf_pkg::COORD_BITS-1:0] req_y_value,
   input  logic                                   req_last_point,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [lslf_pkg::OUT_W-1:0]      rsp_slope,
   output logic signed [lslf_pkg::OUT_W-1:0]      rsp_intercept,
   output logic [lslf_pkg::RSQ_W-1:0]             rsp_r_squared,
   output logic [lslf_pkg::STAT_W-1:0]            rsp_fit_status
);
   import lslf_pkg::*;

   logic           req_accept;
   logic           busy;
   logic           out_load;
   logic           out_free;
   sums_type       sums;
   alu_req_type    alu_req;
   logic [ALU_W-1:0] alu_a, alu_b, alu_result;
   logic           alu_done;
   fit_result_type fit_res;
   fit_result_type rsp_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   lslf_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .x_value (req_x_value),
      .y_value (req_y_value),
      .clear   (out_load),
      .sums    (sums)
   );

   lslf_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .done   (alu_done),
      .result (alu_result)
   );

   lslf_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept && req_last_point),
      .sums       (sums),
      .out_free   (out_free),
      .alu_done   (alu_done),
      .alu_result (alu_result),
      .alu_req    (alu_req),
      .alu_a      (alu_a),
      .alu_b      (alu_b),
      .busy       (busy),
      .out_load   (out_load),
      .result     (fit_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_ff <= fit_res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slope      = rsp_ff.slope;
   assign rsp_intercept  = rsp_ff.intercept;
   assign rsp_r_squared  = rsp_ff.r_squared;
   assign rsp_fit_status = rsp_ff.fit_status;

endmodule

### rtl/lslf_checker.sv
// ----------------------------------------------------------------------------
// lslf_checker
// port-level checks of the line fit unit, bound to the top level
// ----------------------------------------------------------------------------
`include "least_squares_line_fit_unit_macros.svh"

module lslf_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic signed [lslf_pkg::COORD_BITS-1:0] req_x_value,
   input logic signed [lslf_pkg::COORD_BITS-1:0] req_y_value,
   input logic                                   req_last_point,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [lslf_pkg::OUT_W-1:0]      rsp_slope,
   input logic signed [lslf_pkg::OUT_W-1:0]      rsp_intercept,
   input logic [lslf_pkg::RSQ_W-1:0]             rsp_r_squared,
   input logic [lslf_pkg::STAT_W-1:0]            rsp_fit_status
);
   import lslf_pkg::*;

   `LSLF_ASSERT_ALWAYS_NEXT(a_reset_clears, reset, !rsp_valid, "result valid after reset")

   `LSLF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "stalled result dropped")

   `LSLF_ASSERT_NEXT(a_last_busy, req_valid && !req_stall && req_last_point, req_stall, "no stall after last request")

   `LSLF_ASSERT_SAME(a_vert_zero, rsp_valid && rsp_fit_status == STAT_VERT, rsp_slope == '0 && rsp_intercept == '0 && rsp_r_squared == '0, "vertical fit with nonzero fields")

   `LSLF_ASSERT_SAME(a_flat_rsq, rsp_valid && rsp_fit_status == STAT_FLAT, rsp_r_squared == '0, "flat fit with nonzero r-squared")

endmodule

bind least_squares_line_fit_unit lslf_checker u_lslf_checker (.*);

### sim/least_squares_line_fit_checker.sv
// ----------------------------------------------------------------------------
// least_squares_line_fit_checker
// watches both channels of the line fit unit: every accepted point updates
// an exact copy of the running sums, every point with the last flag queues
// the expected fit, and every accepted result is compared with the oldest one
// ----------------------------------------------------------------------------
module least_squares_line_fit_checker
   import lslf_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_x_value,
   input  logic signed [COORD_BITS-1:0] req_y_value,
   input  logic                         req_last_point,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [OUT_W-1:0]      rsp_slope,
   input  logic signed [OUT_W-1:0]      rsp_intercept,
   input  logic [RSQ_W-1:0]             rsp_r_squared,
   input  logic [STAT_W-1:0]            rsp_fit_status,
   output int                           fail_count,
   output int                           fits_pending
);

   localparam int WIDE = 256;
   typedef logic signed [WIDE-1:0] wide_type;

   int             pts;
   wide_type       acc_x, acc_y, acc_xx, acc_yy, acc_xy;
   fit_result_type fit_queue[$];

   function automatic logic [OUT_W-1:0] clamp48(input wide_type q, inout logic sat);
      wide_type top_pos, top_neg;
      top_pos = (wide_type'(1) <<< (OUT_W - 1)) - 1;
      top_neg = -(wide_type'(1) <<< (OUT_W - 1));
      if (q > top_pos) begin
         sat = 1'b1;
         return top_pos[OUT_W-1:0];
      end
      if (q < top_neg) begin
         sat = 1'b1;
         return top_neg[OUT_W-1:0];
      end
      return q[OUT_W-1:0];
   endfunction

   function automatic fit_result_type predict_fit();
      fit_result_type r;
      wide_type       n, dx, dy, dxy, inum, q;
      logic           sat;
      sat = 1'b0;
      r = '0;
      n = wide_type'(pts);
      dx = n * acc_xx - acc_x * acc_x;
      dy = n * acc_yy - acc_y * acc_y;
      dxy = n * acc_xy - acc_x * acc_y;
      if (dx == 0) begin
         r.fit_status = STAT_VERT;
      end else begin
         r.slope = clamp48((dxy <<< FRAC_BITS) / dx, sat);
         inum = acc_y * acc_xx - acc_x * acc_xy;
         r.intercept = clamp48((inum <<< FRAC_BITS) / dx, sat);
         if (dy != 0) begin
            q = ((dxy * dxy) <<< FRAC_BITS) / (dx * dy);
            if (q > (wide_type'(1) <<< FRAC_BITS))
               q = wide_type'(1) <<< FRAC_BITS;
            r.r_squared = q[RSQ_W-1:0];
         end
         r.fit_status = sat ? STAT_SAT : (dy == 0 ? STAT_FLAT : STAT_OK);
      end
      return r;
   endfunction

   task automatic clear_sums();
      pts = 0;
      acc_x = 0;
      acc_y = 0;
      acc_xx = 0;
      acc_yy = 0;
      acc_xy = 0;
   endtask

   task automatic compare(input string field, input logic [OUT_W-1:0] expv,
                          input logic [OUT_W-1:0] actv);
      if (expv !== actv) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, expv, actv);
         fail_count++;
      end
   endtask

   assign fits_pending = fit_queue.size();

   initial begin
      fail_count = 0;
      clear_sums();
   end

   always @(posedge clock) begin
      fit_result_type e;
      wide_type       xw, yw;
      if (reset) begin
         clear_sums();
      end else begin
         if (req_valid && !req_stall) begin
            xw = wide_type'(req_x_value);
            yw = wide_type'(req_y_value);
            if (pts < MAX_POINTS) begin
               pts++;
               acc_x += xw;
               acc_y += yw;
               acc_xx += xw * xw;
               acc_yy += yw * yw;
               acc_xy += xw * yw;
            end
            if (req_last_point) begin
               fit_queue.push_back(predict_fit());
               clear_sums();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (fit_queue.size() == 0) begin
               $display("%0t: unexpected result, slope %0h status %0d", $time, rsp_slope,
                        rsp_fit_status);
               fail_count++;
            end else begin
               e = fit_queue.pop_front();
               compare("slope", e.slope, rsp_slope);
               compare("intercept", e.intercept, rsp_intercept);
               compare("r_squared", OUT_W'(e.r_squared), OUT_W'(rsp_r_squared));
               compare("fit_status", OUT_W'(e.fit_status), OUT_W'(rsp_fit_status));
            end
         end
      end
   end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the least-squares line fit unit: directed sets
// for vertical, flat, single-point, extreme and saturating sets, then
// random sets of mixed shape with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module testbench;
   import lslf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 4000;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [COORD_BITS-1:0] req_x_value;
   logic signed [COORD_BITS-1:0] req_y_value;
   logic                         req_last_point;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [OUT_W-1:0]      rsp_slope;
   logic signed [OUT_W-1:0]      rsp_intercept;
   logic [RSQ_W-1:0]             rsp_r_squared;
   logic [STAT_W-1:0]            rsp_fit_status;
   int                           fail_count;
   int                           fits_pending;
   int                           idle_cycles;
   bit                           hold_wanted;
   bit                           no_gaps;

   least_squares_line_fit_unit DUT (.*);
   least_squares_line_fit_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 300);
   endfunction

   task automatic send_point(input int x, input int y, input bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_value <= COORD_BITS'(x);
      req_y_value <= COORD_BITS'(y);
      req_last_point <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // one set of n points; shape picks how the points relate
   task automatic send_set(input int n, input int shape);
      int bx, by, i, x, y, slope;
      bx = $urandom_range(0, 65535) - 32768;
      by = $urandom_range(0, 65535) - 32768;
      slope = $urandom_range(0, 8) - 4;
      for (i = 0; i < n; i++) begin
         x = $urandom_range(0, 65535) - 32768;
         y = $urandom_range(0, 65535) - 32768;
         case (shape)
            1: x = bx;
            2: y = by;
            3: begin
               x = bx + $urandom_range(0, 6) - 3;
               y = by + $urandom_range(0, 6) - 3;
            end
            4: begin
               x = $urandom_range(0, 2000) - 1000;
               y = slope * x + by / 4 + $urandom_range(0, 4) - 2;
            end
            5: begin
               x = $urandom_range(0, 1) ? 32767 : -32768;
               y = $urandom_range(0, 1) ? 32767 : -32768;
            end
            default: ;
         endcase
         if (x > 32767) x = 32767;
         if (x < -32768) x = -32768;
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         send_point(x, y, i == n - 1);
      end
   endtask

   // receiver: random stalls, one long hold on request
   initial begin
      int s, r;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            s = r < 80 ? $urandom_range(1, 3) : $urandom_range(20, 200);
            rsp_stall <= 1'b1;
            repeat (s) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         s = r < 70 ? $urandom_range(1, 5) : $urandom_range(50, 800);
         rsp_stall <= 1'b0;
         repeat (s) @(posedge clock);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int sent, n, r;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_x_value <= '0;
      req_y_value <= '0;
      req_last_point <= 1'b0;
      hold_wanted = 1'b0;
      no_gaps = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed sets
      send_point(32767, -32768, 1'b1);
      send_point(-32768, 0, 1'b0);
      send_point(32767, 0, 1'b1);
      send_point(-32768, -32768, 1'b0);
      send_point(32767, 32767, 1'b1);
      send_point(5, 1, 1'b0);
      send_point(5, 2, 1'b0);
      send_point(5, 3, 1'b1);
      send_point(-3, 7, 1'b0);
      send_point(4, 7, 1'b0);
      send_point(9, 7, 1'b1);
      send_point(32767, -32768, 1'b0);
      send_point(32766, 32767, 1'b0);
      send_point(32767, -32767, 1'b1);
      send_point(-32768, 32767, 1'b0);
      send_point(-32767, -32768, 1'b1);
      send_point(1, 2, 1'b0);
      send_point(2, 1, 1'b0);
      send_point(3, 3, 1'b1);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (fits_pending == 0);

      // random sets
      hold_wanted = 1'b1;
      sent = 0;
      while (sent < 1150) begin
         r = $urandom_range(0, 99);
         if (r < 5) n = 1;
         else if (r < 75) n = $urandom_range(2, 12);
         else if (r < 95) n = $urandom_range(13, 60);
         else n = $urandom_range(100, 200);
         no_gaps = $urandom_range(0, 99) < 25;
         send_set(n, $urandom_range(0, 7));
         sent += n;
      end
      req_valid <= 1'b0;
      @(posedge clock);

      wait (fits_pending == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/lslf_pkg.sv
rtl/lslf_accum.sv
rtl/lslf_alu.sv
rtl/lslf_seq.sv
rtl/least_squares_line_fit_unit.sv
rtl/lslf_checker.sv
sim/least_squares_line_fit_checker.sv
sim/testbench.sv
